// ===== hdl/krt_pkg.sv =====
// krt_pkg: types and codes for the keyed record table.
// Used by krt_store and keyed_record_table_unit; depends on nothing.
package krt_pkg;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;
    localparam logic [1:0] OP_LIST   = 2'd3;

    localparam int USED_W = 5;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [7:0]  key;
        logic [15:0] year;
        logic [7:0]  subject_0;
        logic [7:0]  subject_1;
        logic [7:0]  subject_2;
        logic [7:0]  grade_0;
        logic [7:0]  grade_1;
        logic [7:0]  grade_2;
    } req_t;

    typedef struct packed {
        logic        ok;
        logic [15:0] out_year;
        logic [7:0]  out_subject_0;
        logic [7:0]  out_subject_1;
        logic [7:0]  out_subject_2;
        logic [7:0]  out_grade_0;
        logic [7:0]  out_grade_1;
        logic [7:0]  out_grade_2;
        logic [7:0]  listed_key;
        logic [4:0]  used_count;
        logic        table_full;
        logic        last;
    } rsp_t;

    // subjects/grades: entry 0 in bits 7:0, entry 2 in bits 23:16
    typedef struct packed {
        logic [7:0]  key;
        logic [15:0] year;
        logic [23:0] subjects;
        logic [23:0] grades;
    } rec_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } mem_ctl_t;

endpackage

// ===== hdl/keyed_record_table_unit.sv =====
// keyed_record_table_unit: compacting keyed record table, one item at a time.
// Add, and any op on an empty table, reaches the result register in the cycle after it is accepted.
// Read/delete: memory scan, one entry per cycle, then the result is posted once the result register is free.
// List: keys are read out in slot order, one key per cycle unless stalled.
// Reset: control and fill count clear; record memory holds no reset value.
// Depends on krt_pkg and krt_store.
module keyed_record_table_unit #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  krt_pkg::req_t   req,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output krt_pkg::rsp_t   rsp
);

    localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int USED_W = krt_pkg::USED_W;

    // sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;  // read/delete sweep
    localparam logic [1:0] ST_LIST = 2'd2;  // one key per beat
    localparam logic [1:0] ST_DONE = 2'd3;  // post read/delete result

    logic [1:0]       state_reg, state_next;
    logic [1:0]       op_reg, op_next;
    logic [7:0]       key_reg, key_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] issue_reg, issue_next;   // next slot to read
    logic             rd_vld_reg, rd_vld_next; // store read data valid
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next; // slot of store read data
    logic             hit_reg, hit_next;
    krt_pkg::rec_t    hit_rec_reg, hit_rec_next;
    logic             rsp_valid_reg, rsp_valid_next;
    krt_pkg::rsp_t    rsp_reg, rsp_next;

    krt_pkg::mem_ctl_t mem_ctl;
    logic [IDX_W-1:0]  rd_addr;
    logic [IDX_W-1:0]  wr_addr;
    krt_pkg::rec_t     wr_data;
    krt_pkg::rec_t     rd_data;

    logic             out_free;
    logic             accept;
    logic             consume;
    logic             key_match;
    logic [CNT_W-1:0] count_after;

    krt_store #(
        .DEPTH (TABLE_DEPTH)
    ) u_store (
        .clk     (clk),
        .ctl     (mem_ctl),
        .rd_addr (rd_addr),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_data (rd_data)
    );

    // result register can take a beat this cycle
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign req_stall = !((state_reg == ST_IDLE) && out_free);
    assign accept    = req_valid && !req_stall;
    assign key_match = (rd_data.key == key_reg);

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        count_next     = count_reg;
        issue_next     = issue_reg;
        rd_vld_next    = rd_vld_reg;
        rd_idx_next    = rd_idx_reg;
        hit_next       = hit_reg;
        hit_rec_next   = hit_rec_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_stall ? rsp_valid_reg : 1'b0;
        consume        = 1'b0;
        count_after    = count_reg;

        mem_ctl.rd_en = 1'b0;
        mem_ctl.wr_en = 1'b0;
        rd_addr       = issue_reg[IDX_W-1:0];
        wr_addr       = count_reg[IDX_W-1:0];
        wr_data.key      = req.key;
        wr_data.year     = req.year;
        wr_data.subjects = {req.subject_2, req.subject_1, req.subject_0};
        wr_data.grades   = {req.grade_2, req.grade_1, req.grade_0};

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req.opcode == krt_pkg::OP_ADD)
                    begin
                        rsp_next = '0;
                        if (count_reg < CNT_W'(TABLE_DEPTH))
                        begin
                            mem_ctl.wr_en = 1'b1;
                            count_after   = count_reg + CNT_W'(1);
                            rsp_next.ok   = 1'b1;
                        end
                        count_next          = count_after;
                        rsp_next.used_count = USED_W'(count_after);
                        rsp_next.table_full = (count_after == CNT_W'(TABLE_DEPTH));
                        rsp_next.last       = 1'b1;
                        rsp_valid_next      = 1'b1;
                    end
                    else if (count_reg == '0)
                    begin
                        // empty table: single miss beat
                        rsp_next            = '0;
                        rsp_next.table_full = (count_reg == CNT_W'(TABLE_DEPTH));
                        rsp_next.last       = 1'b1;
                        rsp_valid_next      = 1'b1;
                    end
                    else
                    begin
                        op_next    = req.opcode;
                        key_next   = req.key;
                        issue_next = '0;
                        hit_next   = 1'b0;
                        state_next = (req.opcode == krt_pkg::OP_LIST) ? ST_LIST : ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                mem_ctl.rd_en = (issue_reg < count_reg);
                rd_vld_next   = mem_ctl.rd_en;
                if (mem_ctl.rd_en)
                begin
                    issue_next  = issue_reg + CNT_W'(1);
                    rd_idx_next = issue_reg[IDX_W-1:0];
                end
                if (rd_vld_reg)
                begin
                    if (op_reg == krt_pkg::OP_DELETE)
                    begin
                        // after the first match every later slot moves down one
                        if (hit_reg)
                        begin
                            mem_ctl.wr_en = 1'b1;
                            wr_addr       = rd_idx_reg - IDX_W'(1);
                            wr_data       = rd_data;
                        end
                        else if (key_match)
                        begin
                            hit_next = 1'b1;
                        end
                    end
                    else if (key_match)
                    begin
                        // read: last match wins
                        hit_next     = 1'b1;
                        hit_rec_next = rd_data;
                    end
                    if (issue_reg == count_reg)
                    begin
                        state_next = ST_DONE;
                    end
                end
            end

            ST_DONE:
            begin
                if (out_free)
                begin
                    if ((op_reg == krt_pkg::OP_DELETE) && hit_reg)
                    begin
                        count_after = count_reg - CNT_W'(1);
                    end
                    count_next = count_after;
                    rsp_next   = '0;
                    rsp_next.ok = hit_reg;
                    if ((op_reg == krt_pkg::OP_READ) && hit_reg)
                    begin
                        rsp_next.out_year      = hit_rec_reg.year;
                        rsp_next.out_subject_0 = hit_rec_reg.subjects[7:0];
                        rsp_next.out_subject_1 = hit_rec_reg.subjects[15:8];
                        rsp_next.out_subject_2 = hit_rec_reg.subjects[23:16];
                        rsp_next.out_grade_0   = hit_rec_reg.grades[7:0];
                        rsp_next.out_grade_1   = hit_rec_reg.grades[15:8];
                        rsp_next.out_grade_2   = hit_rec_reg.grades[23:16];
                    end
                    rsp_next.used_count = USED_W'(count_after);
                    rsp_next.table_full = (count_after == CNT_W'(TABLE_DEPTH));
                    rsp_next.last       = 1'b1;
                    rsp_valid_next      = 1'b1;
                    state_next          = ST_IDLE;
                end
            end

            ST_LIST:
            begin
                // store read data holds while the result register is blocked
                consume       = rd_vld_reg && out_free;
                mem_ctl.rd_en = (issue_reg < count_reg) && (!rd_vld_reg || out_free);
                if (mem_ctl.rd_en)
                begin
                    issue_next  = issue_reg + CNT_W'(1);
                    rd_idx_next = issue_reg[IDX_W-1:0];
                    rd_vld_next = 1'b1;
                end
                else if (consume)
                begin
                    rd_vld_next = 1'b0;
                end
                if (consume)
                begin
                    rsp_next            = '0;
                    rsp_next.ok         = 1'b1;
                    rsp_next.listed_key = rd_data.key;
                    rsp_next.used_count = USED_W'(count_reg);
                    rsp_next.table_full = (count_reg == CNT_W'(TABLE_DEPTH));
                    rsp_next.last       = ((CNT_W'(rd_idx_reg) + CNT_W'(1)) == count_reg);
                    rsp_valid_next      = 1'b1;
                    if (rsp_next.last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= krt_pkg::OP_ADD;
            count_reg     <= '0;
            issue_reg     <= '0;
            rd_vld_reg    <= 1'b0;
            rd_idx_reg    <= '0;
            hit_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            count_reg     <= count_next;
            issue_reg     <= issue_next;
            rd_vld_reg    <= rd_vld_next;
            rd_idx_reg    <= rd_idx_next;
            hit_reg       <= hit_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        key_reg     <= key_next;
        hit_rec_reg <= hit_rec_next;
        rsp_reg     <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== hdl/krt_store.sv =====
// krt_store: record memory, one write port and one registered read port.
// Depends on krt_pkg (rec_t, mem_ctl_t).
module krt_store #(
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  krt_pkg::mem_ctl_t                     ctl,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  krt_pkg::rec_t                         wr_data,
    output krt_pkg::rec_t                         rd_data
);

    krt_pkg::rec_t rec_mem [DEPTH];
    krt_pkg::rec_t rd_data_reg;

    // read data holds when no read is issued
    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_data_reg <= rec_mem[rd_addr];
        end
        if (ctl.wr_en)
        begin
            rec_mem[wr_addr] <= wr_data;
        end
    end

    assign rd_data = rd_data_reg;

endmodule
